### src/scd_pkg.sv
// Package for the sector cache directory: sizes, access codes and shared types.
// No dependencies; used by every module under src.
package scd_pkg;

  // Directory geometry
  localparam int NUM_ENTRIES  = 3;
  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int ADDR_W       = 32;
  localparam int TAG_W        = 23;
  localparam int AGE_W        = 16;
  localparam int WAY_W        = $clog2(NUM_ENTRIES);
  localparam int WAY_FIELD_W  = 2;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  typedef logic [TAG_W-1:0]       tag_t;
  typedef logic [AGE_W-1:0]       age_t;
  typedef logic [WAY_W-1:0]       way_t;
  typedef logic [WAY_FIELD_W-1:0] way_field_t;

  // Access codes; the unused code behaves as a fetch
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FETCH = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  // Write-back of one directory entry
  typedef struct packed {
    logic  en;
    way_t  way;
    tag_t  tag;
    age_t  age;
    logic  dirty;
  } dir_upd_t;

  // One result transaction
  typedef struct packed {
    tag_t       wb_sector;
    logic       writeback;
    way_field_t way;
    logic       hit;
  } result_t;

  // Reset contents: the first three entries are preloaded, the rest are clear
  function automatic tag_t reset_tag(int idx);
    tag_t t;
    case (idx)
      1:       t = tag_t'(6552);
      2:       t = tag_t'(3011);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic age_t reset_age(int idx);
    age_t a;
    a = (idx == 0) ? AGE_MAX : '0;
    return a;
  endfunction

endpackage

### src/scd_dir.sv
// Directory storage: tag, age and dirty mark per entry, with preloaded reset values.
// Depends on scd_pkg.
module scd_dir (
  input  logic              clk,
  input  logic              rst_n,
  input  scd_pkg::dir_upd_t upd,
  output scd_pkg::tag_t     tags   [scd_pkg::NUM_ENTRIES],
  output scd_pkg::age_t     ages   [scd_pkg::NUM_ENTRIES],
  output logic              dirties[scd_pkg::NUM_ENTRIES]
);
  import scd_pkg::*;

  tag_t tag_r  [NUM_ENTRIES];
  age_t age_r  [NUM_ENTRIES];
  logic dirty_r[NUM_ENTRIES];

  // One entry is rewritten per processed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        tag_r[i]   <= reset_tag(i);
        age_r[i]   <= reset_age(i);
        dirty_r[i] <= 1'b0;
      end
    end else if (upd.en) begin
      tag_r[upd.way]   <= upd.tag;
      age_r[upd.way]   <= upd.age;
      dirty_r[upd.way] <= upd.dirty;
    end
  end

  assign tags    = tag_r;
  assign ages    = age_r;
  assign dirties = dirty_r;

endmodule

### src/scd_lookup.sv
// Lookup and replacement logic: tag match, victim choice, age and dirty update.
// Depends on scd_pkg; purely combinational.
module scd_lookup (
  input  logic                 valid,
  input  logic [scd_pkg::ADDR_W-1:0] address,
  input  scd_pkg::mode_t       mode,
  input  scd_pkg::tag_t        tags   [scd_pkg::NUM_ENTRIES],
  input  scd_pkg::age_t        ages   [scd_pkg::NUM_ENTRIES],
  input  logic                 dirties[scd_pkg::NUM_ENTRIES],
  output scd_pkg::result_t     res,
  output scd_pkg::dir_upd_t    upd
);
  import scd_pkg::*;

  logic [ADDR_W-1:0] sector_full;
  tag_t              sector;
  logic              instr;
  logic              hit;
  way_t              hit_way;
  way_t              data_way;
  way_t              fetch_way;
  logic              fetch_found;
  way_t              way;
  logic              victim_dirty;
  tag_t              victim_tag;
  age_t              base_age;
  logic [AGE_W:0]    age_sum;
  age_t              new_age;
  logic              new_dirty;

  assign sector_full = address >> SECTOR_SHIFT;
  assign sector      = sector_full[TAG_W-1:0];
  assign instr       = (mode != MODE_READ) && (mode != MODE_WRITE);

  // Tag match across all entries, highest index wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (tags[i] == sector) begin
        hit     = 1'b1;
        hit_way = way_t'(i);
      end
    end
  end

  // Data victim: least age, ties to the higher index
  always_comb begin
    data_way = way_t'(NUM_ENTRIES - 1);
    for (int i = NUM_ENTRIES - 2; i >= 0; i--) begin
      if (ages[i] < ages[data_way]) data_way = way_t'(i);
    end
  end

  // Fetch victim: lowest saturated entry, else the last one
  always_comb begin
    fetch_way   = way_t'(NUM_ENTRIES - 1);
    fetch_found = 1'b0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (!fetch_found && ages[i] == AGE_MAX) begin
        fetch_way   = way_t'(i);
        fetch_found = 1'b1;
      end
    end
  end

  assign way          = hit ? hit_way : (instr ? fetch_way : data_way);
  assign victim_dirty = dirties[way];
  assign victim_tag   = tags[way];

  // Age: reload on a miss, then a saturating-skip bump for data accesses
  always_comb begin
    if (hit)        base_age = ages[way];
    else if (instr) base_age = AGE_MAX;
    else            base_age = '0;
    age_sum = {1'b0, base_age} + ((mode == MODE_WRITE) ? (AGE_W+1)'(1) : (AGE_W+1)'(2));
    if (instr || age_sum[AGE_W]) new_age = base_age;
    else                         new_age = age_sum[AGE_W-1:0];
  end

  assign new_dirty = (mode == MODE_WRITE) ? 1'b1 : (hit & victim_dirty);

  always_comb begin
    upd.en    = valid;
    upd.way   = way;
    upd.tag   = sector;
    upd.age   = new_age;
    upd.dirty = new_dirty;

    res.hit       = hit;
    res.way       = way_field_t'(way);
    res.writeback = !hit && victim_dirty;
    res.wb_sector = (!hit && victim_dirty) ? victim_tag : '0;
  end

endmodule

### src/sector_cache_directory_unit.sv
// Top level of the sector cache directory: input register, lookup, result register.
// Depends on scd_pkg, scd_dir and scd_lookup.
//
// Usage: each input transaction carries a byte address (in_tdata) and an access
// mode (in_tuser: data read, data write or instruction fetch). For every input
// transaction exactly one result comes out on the out_ channel: hit flag, the
// entry that now holds the sector, and a write-back flag with the old sector of
// a dirty victim.
// Timing: a transaction accepted into the input register is looked up from there,
// and its result is captured in the result register once that register can take it.
// Throughput: one transaction per cycle if not stalled; tag compare, victim choice,
// age update for an entry all settle between the input and result registers, and
// the directory is written at the same edge, so the next access sees it.
// Stall: while out_tvalid is high and out_tready low, the held input waits in
// the input register and in_tready drops once that register is full.
// Reset (rst_n low, synchronous): both channels empty, directory preloaded
// with its fixed start tags, ages and clean entries; no clearing pass.
module sector_cache_directory_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] address
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [0] hit, [2:1] way, [3] writeback,
                                  // [26:4] writeback_sector, [31:27] zero
);
  import scd_pkg::*;

  logic              in_valid_r;
  logic [ADDR_W-1:0] in_addr_r;
  mode_t             in_mode_r;
  logic              out_valid_r;
  result_t           out_res_r;
  logic              advance;
  tag_t              tags   [NUM_ENTRIES];
  age_t              ages   [NUM_ENTRIES];
  logic              dirties[NUM_ENTRIES];
  result_t           res;
  dir_upd_t          upd_raw;
  dir_upd_t          upd;

  // Move the held transaction on when the result slot is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_addr_r <= in_tdata;
      in_mode_r <= mode_t'(in_tuser);
    end
  end

  scd_dir u_dir (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .tags    (tags),
    .ages    (ages),
    .dirties (dirties)
  );

  scd_lookup u_lookup (
    .valid   (advance),
    .address (in_addr_r),
    .mode    (in_mode_r),
    .tags    (tags),
    .ages    (ages),
    .dirties (dirties),
    .res     (res),
    .upd     (upd_raw)
  );

  assign upd = upd_raw;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32 - $bits(result_t)){1'b0}}, out_res_r};

endmodule
